// File: src/sdfpd_pkg.sv
// ----------------------------------------------------------------------------
// sdfpd_pkg
// shared types, widths and helpers for the primitive distance pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sdfpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int DIFF_W    = IN_W + 1;             // p - c
    localparam int DOT_W     = 2 * IN_W + 3;         // sum of three products
    localparam int T_W       = 37;                   // projection coefficient
    localparam int TA_W      = T_W + IN_W;           // t * a
    localparam int W_W       = TA_W - FRAC_BITS + 1; // v - t*a
    localparam int HALF_W    = (W_W + 1) / 2;        // split for squaring
    localparam int SQ_W      = 2 * W_W;              // one square
    localparam int SUM_W     = 2 * W_W + 2;          // sum of squares, even
    localparam int ROOT_W    = SUM_W / 2;            // root bits = sqrt stages
    localparam int REM_W     = ROOT_W + 2;

    localparam logic signed [DOT_W-1:0] T_LIMIT = DOT_W'(64'sd34359738368);

    typedef enum logic [1:0] {
        CMD_SPHERE   = 2'd0,
        CMD_CYLINDER = 2'd1,
        CMD_PLANE    = 2'd2,
        CMD_BOX      = 2'd3
    } t_cmd;

    // result bookkeeping that rides along the root pipeline
    typedef struct packed {
        logic                   use_byp;
        logic                   sub_s;
        logic signed [IN_W-1:0] s;
        logic signed [IN_W-1:0] byp;
    } t_side;

    function automatic logic signed [IN_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [IN_W-1:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[IN_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/sdf_primitive_distance_core.sv
// ----------------------------------------------------------------------------
// sdf_primitive_distance_core
// signed distance from a point to a sphere, cylinder, plane or box, Q16.16
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  command   in         i_start, o_busy       i_cmd, i_pos_*, i_center_*,
//                                             i_axis_*, i_scalar
//  result    out        o_valid (strobe)      o_distance_out
//
//  a beat is taken at every edge with i_start high; o_busy stays low
//  each result passes through 9 arithmetic stages, 55 root stages of one
//  bit each and one output register
//  latency is set by the bit-serial square root over the 110-bit sum
//  reset is synchronous, active low, and clears only the valid chain
//  there is no stall: results stream out in command order
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_primitive_distance_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [1:0]                i_cmd,
    input  wire logic signed [31:0]        i_pos_x,
    input  wire logic signed [31:0]        i_pos_y,
    input  wire logic signed [31:0]        i_pos_z,
    input  wire logic signed [31:0]        i_center_x,
    input  wire logic signed [31:0]        i_center_y,
    input  wire logic signed [31:0]        i_center_z,
    input  wire logic signed [31:0]        i_axis_x,
    input  wire logic signed [31:0]        i_axis_y,
    input  wire logic signed [31:0]        i_axis_z,
    input  wire logic signed [31:0]        i_scalar,
    output logic                           o_valid,
    output logic signed [31:0]             o_distance_out
);

    localparam int K   = sdfpd_pkg::ROOT_W;
    localparam int FB  = sdfpd_pkg::FRAC_BITS;
    localparam int HW  = sdfpd_pkg::HALF_W;
    localparam int LAT = K + 10;

    assign o_busy = 1'b0;

    // stage 1: capture, p - c
    logic                    r1_vld;
    sdfpd_pkg::t_cmd         r1_cmd;
    logic signed [31:0]      r1_p [3];
    logic signed [31:0]      r1_a [3];
    logic signed [32:0]      r1_v [3];
    logic signed [31:0]      r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_cmd  <= sdfpd_pkg::t_cmd'(i_cmd);
        r1_p[0] <= i_pos_x;
        r1_p[1] <= i_pos_y;
        r1_p[2] <= i_pos_z;
        r1_a[0] <= i_axis_x;
        r1_a[1] <= i_axis_y;
        r1_a[2] <= i_axis_z;
        r1_v[0] <= 33'(i_pos_x) - 33'(i_center_x);
        r1_v[1] <= 33'(i_pos_y) - 33'(i_center_y);
        r1_v[2] <= 33'(i_pos_z) - 33'(i_center_z);
        r1_s    <= i_scalar;
    end

    // stage 2: dot product terms, box face excess
    logic                    r2_vld;
    sdfpd_pkg::t_cmd         r2_cmd;
    logic signed [31:0]      r2_a [3];
    logic signed [32:0]      r2_v [3];
    logic signed [31:0]      r2_s;
    logic signed [64:0]      r2_prod [3];
    logic signed [33:0]      r2_e [3];

    always_ff @(posedge i_clk) begin
        logic signed [32:0] n_op;
        logic signed [33:0] n_vx;
        logic signed [33:0] n_av;
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_cmd <= r1_cmd;
        r2_s   <= r1_s;
        for (int i = 0; i < 3; i++) begin
            n_op = (r1_cmd == sdfpd_pkg::CMD_PLANE) ? 33'(r1_p[i]) : r1_v[i];
            n_vx = 34'(r1_v[i]);
            n_av = (n_vx < 0) ? -n_vx : n_vx;
            r2_prod[i] <= 65'(n_op) * 65'(r1_a[i]);
            r2_e[i]    <= n_av - 34'(r1_a[i]);
            r2_a[i]    <= r1_a[i];
            r2_v[i]    <= r1_v[i];
        end
    end

    // stage 3: dot sum, box max
    logic                    r3_vld;
    sdfpd_pkg::t_cmd         r3_cmd;
    logic signed [31:0]      r3_a [3];
    logic signed [32:0]      r3_v [3];
    logic signed [31:0]      r3_s;
    logic signed [sdfpd_pkg::DOT_W-1:0] r3_dot;
    logic signed [33:0]      r3_boxm [3];
    logic                    r3_box_in;
    logic signed [31:0]      r3_box_d;

    always_ff @(posedge i_clk) begin
        logic signed [33:0] n_d;
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        n_d = (r2_e[0] > r2_e[1]) ? r2_e[0] : r2_e[1];
        n_d = (n_d > r2_e[2]) ? n_d : r2_e[2];
        r3_cmd    <= r2_cmd;
        r3_s      <= r2_s;
        r3_dot    <= sdfpd_pkg::DOT_W'(r2_prod[0]) + sdfpd_pkg::DOT_W'(r2_prod[1])
                   + sdfpd_pkg::DOT_W'(r2_prod[2]);
        r3_box_in <= (n_d <= 0);
        r3_box_d  <= sdfpd_pkg::sat32(64'(n_d));
        for (int i = 0; i < 3; i++) begin
            r3_a[i]    <= r2_a[i];
            r3_v[i]    <= r2_v[i];
            r3_boxm[i] <= (r2_e[i] > 0) ? r2_e[i] : '0;
        end
    end

    // stage 4: rescale dot, clamp t, plane result
    logic                    r4_vld;
    sdfpd_pkg::t_cmd         r4_cmd;
    logic signed [31:0]      r4_a [3];
    logic signed [32:0]      r4_v [3];
    logic signed [33:0]      r4_boxm [3];
    logic signed [sdfpd_pkg::T_W-1:0] r4_t;
    sdfpd_pkg::t_side        r4_sd;

    always_ff @(posedge i_clk) begin
        logic signed [sdfpd_pkg::DOT_W-1:0] n_sh;
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        n_sh = r3_dot >>> FB;
        if (n_sh > sdfpd_pkg::T_LIMIT) begin
            r4_t <= sdfpd_pkg::T_W'(sdfpd_pkg::T_LIMIT);
        end else if (n_sh < -sdfpd_pkg::T_LIMIT) begin
            r4_t <= sdfpd_pkg::T_W'(-sdfpd_pkg::T_LIMIT);
        end else begin
            r4_t <= n_sh[sdfpd_pkg::T_W-1:0];
        end
        r4_cmd        <= r3_cmd;
        r4_sd.s       <= r3_s;
        r4_sd.sub_s   <= (r3_cmd != sdfpd_pkg::CMD_BOX);
        r4_sd.use_byp <= (r3_cmd == sdfpd_pkg::CMD_PLANE)
                      || ((r3_cmd == sdfpd_pkg::CMD_BOX) && r3_box_in);
        r4_sd.byp     <= (r3_cmd == sdfpd_pkg::CMD_PLANE)
                      ? sdfpd_pkg::sat32(64'(n_sh) + 64'(r3_s)) : r3_box_d;
        for (int i = 0; i < 3; i++) begin
            r4_a[i]    <= r3_a[i];
            r4_v[i]    <= r3_v[i];
            r4_boxm[i] <= r3_boxm[i];
        end
    end

    // stage 5: t * a
    logic                    r5_vld;
    sdfpd_pkg::t_cmd         r5_cmd;
    logic signed [32:0]      r5_v [3];
    logic signed [33:0]      r5_boxm [3];
    logic signed [sdfpd_pkg::TA_W-1:0] r5_ta [3];
    sdfpd_pkg::t_side        r5_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_cmd <= r4_cmd;
        r5_sd  <= r4_sd;
        for (int i = 0; i < 3; i++) begin
            r5_ta[i]   <= sdfpd_pkg::TA_W'(r4_t) * sdfpd_pkg::TA_W'(r4_a[i]);
            r5_v[i]    <= r4_v[i];
            r5_boxm[i] <= r4_boxm[i];
        end
    end

    // stage 6: pick the vector to measure, take magnitudes
    logic                    r6_vld;
    logic [sdfpd_pkg::W_W-1:0] r6_m [3];
    sdfpd_pkg::t_side        r6_sd;

    always_ff @(posedge i_clk) begin
        logic signed [sdfpd_pkg::W_W-1:0] n_x;
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_sd <= r5_sd;
        for (int i = 0; i < 3; i++) begin
            case (r5_cmd)
                sdfpd_pkg::CMD_SPHERE:   n_x = sdfpd_pkg::W_W'(r5_v[i]);
                sdfpd_pkg::CMD_CYLINDER: n_x = sdfpd_pkg::W_W'(r5_v[i])
                    - sdfpd_pkg::W_W'($signed(r5_ta[i][sdfpd_pkg::TA_W-1:FB]));
                sdfpd_pkg::CMD_BOX:      n_x = sdfpd_pkg::W_W'(r5_boxm[i]);
                default:                 n_x = '0;
            endcase
            r6_m[i] <= (n_x < 0) ? unsigned'(-n_x) : unsigned'(n_x);
        end
    end

    // stage 7: partial products of the squares
    logic                    r7_vld;
    logic [2*HW-1:0]         r7_hh [3];
    logic [2*HW-1:0]         r7_hl [3];
    logic [2*HW-1:0]         r7_ll [3];
    sdfpd_pkg::t_side        r7_sd;

    always_ff @(posedge i_clk) begin
        logic [HW-1:0] n_hi;
        logic [HW-1:0] n_lo;
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_sd <= r6_sd;
        for (int i = 0; i < 3; i++) begin
            n_hi = HW'(r6_m[i] >> HW);
            n_lo = r6_m[i][HW-1:0];
            r7_hh[i] <= (2*HW)'(n_hi) * (2*HW)'(n_hi);
            r7_hl[i] <= (2*HW)'(n_hi) * (2*HW)'(n_lo);
            r7_ll[i] <= (2*HW)'(n_lo) * (2*HW)'(n_lo);
        end
    end

    // stage 8: assemble squares
    logic                    r8_vld;
    logic [sdfpd_pkg::SQ_W-1:0] r8_sq [3];
    sdfpd_pkg::t_side        r8_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
        r8_sd <= r7_sd;
        for (int i = 0; i < 3; i++) begin
            r8_sq[i] <= (sdfpd_pkg::SQ_W'(r7_hh[i]) << (2*HW))
                      + (sdfpd_pkg::SQ_W'(r7_hl[i]) << (HW+1))
                      + sdfpd_pkg::SQ_W'(r7_ll[i]);
        end
    end

    // stage 9 and the root chain: one result bit per stage
    logic                       r_vld [K+1];
    sdfpd_pkg::t_side           r_sd  [K+1];
    logic [sdfpd_pkg::SUM_W-1:0] r_n  [K+1];
    logic [sdfpd_pkg::REM_W-1:0] r_rem [K+1];
    logic [K-1:0]               r_q   [K+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r8_vld;
        end
        r_sd[0]  <= r8_sd;
        r_n[0]   <= sdfpd_pkg::SUM_W'(r8_sq[0]) + sdfpd_pkg::SUM_W'(r8_sq[1])
                  + sdfpd_pkg::SUM_W'(r8_sq[2]);
        r_rem[0] <= '0;
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < K; k++) begin : g_root
        always_ff @(posedge i_clk) begin
            logic [sdfpd_pkg::REM_W-1:0] n_rs;
            logic [sdfpd_pkg::REM_W-1:0] n_tr;
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            n_rs = {r_rem[k][sdfpd_pkg::REM_W-3:0],
                    r_n[k][sdfpd_pkg::SUM_W-1 -: 2]};
            n_tr = {r_q[k], 2'b01};
            r_sd[k+1] <= r_sd[k];
            r_n[k+1]  <= r_n[k] << 2;
            if (n_rs >= n_tr) begin
                r_rem[k+1] <= n_rs - n_tr;
                r_q[k+1]   <= {r_q[k][K-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_rs;
                r_q[k+1]   <= {r_q[k][K-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        logic signed [63:0] n_len;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[K];
        end
        n_len = $signed(64'(r_q[K]));
        if (r_sd[K].use_byp) begin
            o_distance_out <= r_sd[K].byp;
        end else if (r_sd[K].sub_s) begin
            o_distance_out <= sdfpd_pkg::sat32(n_len - 64'(r_sd[K].s));
        end else begin
            o_distance_out <= sdfpd_pkg::sat32(n_len);
        end
    end

    // every accepted beat comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("result missing after latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without a command");

    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[K] |-> (r_rem[K] <= {1'b0, r_q[K], 1'b0}))
        else $error("root remainder out of bound");

endmodule

`default_nettype wire
